>>> rtl/core/pdc_pkg.sv
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared types and constants for the press duration classifier.
// ----------------------------------------------------------------------------
package pdc_pkg;

    localparam int TIME_W = 48;
    localparam int MS_W   = 16;
    localparam int EVT_W  = 3;
    localparam int IDX_W  = 3;

    localparam logic [MS_W-1:0] HOLD_MAX  = 16'hFFFF;
    localparam int              US_PER_MS = 1000;

    // Hold saturates once the difference reaches (HOLD_MAX + 1) ms.
    localparam logic [TIME_W-1:0] SAT_US = TIME_W'((HOLD_MAX + 1) * US_PER_MS);

    // Below SAT_US the difference fits in LOW_W bits.
    localparam int LOW_W = 26;

    // floor(x / 1000) == (x * RECIP) >> RECIP_SH for every x below 2^LOW_W.
    localparam int                RECIP_SH = 36;
    localparam int                RECIP_W  = 27;
    localparam logic [RECIP_W-1:0] RECIP   = 27'd68719477;
    localparam int                PROD_W   = LOW_W + RECIP_W;

    // Register reset values.
    localparam logic [MS_W-1:0] BOUNCE_RST    = 16'd40;
    localparam logic [MS_W-1:0] LONG_RST      = 16'd3000;
    localparam logic [MS_W-1:0] CALIBRATE_RST = 16'd8000;
    localparam logic [MS_W-1:0] VERY_LONG_RST = 16'd12000;
    localparam logic [MS_W-1:0] ABORT_RST     = 16'd20000;

    typedef enum logic [EVT_W-1:0] {
        EV_NONE      = 3'd0,
        EV_SHORT     = 3'd1,
        EV_LONG      = 3'd2,
        EV_CALIBRATE = 3'd3,
        EV_VERY_LONG = 3'd4
    } event_t;

    typedef enum logic [IDX_W-1:0] {
        REG_BOUNCE    = 3'd0,
        REG_LONG      = 3'd1,
        REG_CALIBRATE = 3'd2,
        REG_VERY_LONG = 3'd3,
        REG_ABORT     = 3'd4
    } reg_index_t;

    // What a sample does to the button state.
    typedef enum logic [1:0] {
        KIND_IDLE    = 2'd0,
        KIND_PRESS   = 2'd1,
        KIND_HOLD    = 2'd2,
        KIND_RELEASE = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] start;
    } stamp_t;

    typedef struct packed {
        kind_t           kind;
        logic [MS_W-1:0] ms;
    } hold_t;

endpackage

>>> rtl/core/pdc_hold_calc.sv
// ----------------------------------------------------------------------------
// pdc_hold_calc
// Two-stage hold time unit: 48-bit difference and saturation check, then
// divide by 1000 through a reciprocal multiply.
// ----------------------------------------------------------------------------
module pdc_hold_calc (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           stamp_valid,
    input  pdc_pkg::stamp_t stamp,
    output logic           hold_valid,
    output pdc_pkg::hold_t hold
);
    import pdc_pkg::*;

    logic              b_valid_reg;
    kind_t             b_kind_reg;
    logic              b_sat_reg;
    logic [LOW_W-1:0]  b_low_reg;

    logic              c_valid_reg;
    hold_t             c_hold_reg;

    logic [TIME_W-1:0] diff;
    logic [PROD_W-1:0] prod;
    logic [MS_W-1:0]   ms_next;

    // Modulo 2^48 difference falls out of the fixed width.
    assign diff = stamp.now - stamp.start;

    assign prod    = PROD_W'(b_low_reg) * PROD_W'(RECIP);
    assign ms_next = b_sat_reg ? HOLD_MAX : prod[RECIP_SH +: MS_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= stamp_valid;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_kind_reg      <= stamp.kind;
            b_sat_reg       <= (diff >= SAT_US);
            b_low_reg       <= diff[LOW_W-1:0];
            c_hold_reg.kind <= b_kind_reg;
            c_hold_reg.ms   <= ms_next;
        end
    end

    assign hold_valid = c_valid_reg;
    assign hold       = c_hold_reg;

endmodule

>>> rtl/core/press_duration_classifier.sv
// ----------------------------------------------------------------------------
// press_duration_classifier
// Active-low button poll classifier: press/release edges, hold time in ms.
// ----------------------------------------------------------------------------
// One sample is taken per clock while the result is not stalled, and each
// produces exactly one result through the input register, difference stage,
// reciprocal multiply stage and result register; the press state and start
// timestamp update as the sample is taken, so back-to-back samples see each
// other's edges. A stalled result holds the whole pipeline. Threshold
// registers are written through cfg_valid/cfg_ready, which is always ready;
// write them only while no sample is in flight.
module press_duration_classifier (
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  logic                       pin_level,
    input  logic [pdc_pkg::TIME_W-1:0] now_us,

    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [pdc_pkg::EVT_W-1:0]  press_event,
    output logic [pdc_pkg::MS_W-1:0]   held_ms,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pdc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [pdc_pkg::MS_W-1:0]   cfg_data
);
    import pdc_pkg::*;

    logic [MS_W-1:0]   bounce_reg;
    logic [MS_W-1:0]   long_reg;
    logic [MS_W-1:0]   calibrate_reg;
    logic [MS_W-1:0]   very_long_reg;
    logic [MS_W-1:0]   abort_reg;

    logic              was_pressed_reg;
    logic [TIME_W-1:0] press_start_reg;

    logic              a_valid_reg;
    stamp_t            a_stamp_reg;

    logic              result_valid_reg;
    event_t            press_event_reg;
    logic [MS_W-1:0]   held_ms_reg;

    logic              advance;
    logic              accept;
    logic              down;
    kind_t             kind;
    logic              hold_valid;
    hold_t             hold;
    event_t            event_next;

    assign advance      = !result_valid_reg || !result_stall;
    assign sample_stall = !advance;
    assign accept       = sample_valid && advance;
    assign cfg_ready    = 1'b1;

    assign down = !pin_level;

    always_comb
    begin
        if (down && !was_pressed_reg)
            kind = KIND_PRESS;
        else if (!down && was_pressed_reg)
            kind = KIND_RELEASE;
        else if (down)
            kind = KIND_HOLD;
        else
            kind = KIND_IDLE;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounce_reg    <= BOUNCE_RST;
            long_reg      <= LONG_RST;
            calibrate_reg <= CALIBRATE_RST;
            very_long_reg <= VERY_LONG_RST;
            abort_reg     <= ABORT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BOUNCE:    bounce_reg    <= cfg_data;
                REG_LONG:      long_reg      <= cfg_data;
                REG_CALIBRATE: calibrate_reg <= cfg_data;
                REG_VERY_LONG: very_long_reg <= cfg_data;
                REG_ABORT:     abort_reg     <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Button state, updated on each sample transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_pressed_reg <= 1'b0;
            press_start_reg <= '0;
        end
        else if (accept)
        begin
            was_pressed_reg <= down;
            if (kind == KIND_PRESS)
                press_start_reg <= now_us;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (advance)
            a_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_stamp_reg.kind  <= kind;
            a_stamp_reg.now   <= now_us;
            a_stamp_reg.start <= press_start_reg;
        end
    end

    pdc_hold_calc u_hold_calc (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .stamp_valid (a_valid_reg),
        .stamp       (a_stamp_reg),
        .hold_valid  (hold_valid),
        .hold        (hold)
    );

    // Release classification, first match wins
    always_comb
    begin
        if (hold.ms < bounce_reg)
            event_next = EV_NONE;
        else if (hold.ms > abort_reg)
            event_next = EV_NONE;
        else if (hold.ms >= very_long_reg)
            event_next = EV_VERY_LONG;
        else if (hold.ms >= calibrate_reg)
            event_next = EV_CALIBRATE;
        else if (hold.ms >= long_reg)
            event_next = EV_LONG;
        else
            event_next = EV_SHORT;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= hold_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            press_event_reg <= (hold.kind == KIND_RELEASE) ? event_next : EV_NONE;
            held_ms_reg     <= (hold.kind == KIND_HOLD) ? hold.ms : '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign press_event  = press_event_reg;
    assign held_ms      = held_ms_reg;

endmodule

>>> rtl/core/pdc_checker.sv
// ----------------------------------------------------------------------------
// pdc_checker
// Port-level checks for the press duration classifier, bound to the top.
// ----------------------------------------------------------------------------
module pdc_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       result_valid,
    input  logic                       result_stall,
    input  logic [pdc_pkg::EVT_W-1:0]  press_event,
    input  logic [pdc_pkg::MS_W-1:0]   held_ms
);
    import pdc_pkg::*;

    // A stalled result stays offered.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // A stalled result does not change.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(press_event) && $stable(held_ms))
        else $error("result changed while stalled");

    // Only defined event codes leave the block.
    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> press_event <= EV_VERY_LONG)
        else $error("undefined press event code");

    // A release result never also reports a live hold time.
    a_event_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && press_event != EV_NONE |-> held_ms == '0)
        else $error("event reported with nonzero hold time");

endmodule

bind press_duration_classifier pdc_checker u_pdc_checker (.*);
